// ===== src/hvn_pkg.sv =====
package hvn_pkg;

    localparam int DIFF_W = 17;
    localparam int SUM_W  = 20;
    localparam int MAG_W  = 19;
    localparam int SQ_W   = 38;
    localparam int S_W    = 40;
    localparam int Q_W    = 15;
    localparam int P_W    = 56;
    localparam int D_W    = 76;
    localparam int HALF_SHIFT = 30;
    localparam int STEPS  = 15;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_W      = 13;

    localparam logic CFG_GRID_COLS = 1'b0;
    localparam logic CFG_GRID_ROWS = 1'b1;

    typedef struct packed {
        logic           neg;
        logic [D_W-1:0] d;
        logic [P_W-1:0] p;
        logic [Q_W-1:0] q;
    } t_lane;

    typedef struct packed {
        logic            vld;
        logic            deg;
        logic [S_W-1:0]  s;
        t_lane [2:0]     lane;
    } t_iter;

endpackage

// ===== src/hvn_front.sv =====
module hvn_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [11:0]                   i_col,
    input  logic [11:0]                   i_row,
    input  logic [15:0]                   i_h,
    input  logic [15:0]                   i_hw,
    input  logic [15:0]                   i_he,
    input  logic [15:0]                   i_hs,
    input  logic [15:0]                   i_hn,
    input  logic [hvn_pkg::CFG_W-1:0]     i_cols,
    input  logic [hvn_pkg::CFG_W-1:0]     i_rows,
    output hvn_pkg::t_iter                o_it
);

    localparam int DW = hvn_pkg::DIFF_W;
    localparam int SW = hvn_pkg::SUM_W;
    localparam int MW = hvn_pkg::MAG_W;

    // stage a: edge differences, quadrant flags
    logic                 r_a_vld;
    logic signed [DW-1:0] r_a_dw, r_a_de, r_a_ds, r_a_dn;
    logic [3:0]           r_a_q;
    logic                 w_hw, w_he, w_hs, w_hn;

    assign w_hw = (i_col != 12'd0);
    assign w_hs = (i_row != 12'd0);
    assign w_he = (({1'b0, i_col} + 13'd1) < i_cols);
    assign w_hn = (({1'b0, i_row} + 13'd1) < i_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
        if (i_en) begin
            r_a_dw <= $signed({i_hw[15], i_hw}) - $signed({i_h[15], i_h});
            r_a_de <= $signed({i_he[15], i_he}) - $signed({i_h[15], i_h});
            r_a_ds <= $signed({i_hs[15], i_hs}) - $signed({i_h[15], i_h});
            r_a_dn <= $signed({i_hn[15], i_hn}) - $signed({i_h[15], i_h});
            r_a_q  <= {w_hw & w_hn, w_he & w_hn, w_he & w_hs, w_hw & w_hs};
        end
    end

    // stage b: summed normal, magnitudes
    logic                 r_b_vld, r_b_deg;
    logic [2:0]           r_b_neg;
    logic [MW-1:0]        r_b_xm, r_b_zm;
    logic [10:0]          r_b_ym;
    logic signed [SW-1:0] w_x, w_z, w_dw, w_de, w_ds, w_dn;
    logic [2:0]           w_cnt;

    assign w_dw = SW'(r_a_dw);
    assign w_de = SW'(r_a_de);
    assign w_ds = SW'(r_a_ds);
    assign w_dn = SW'(r_a_dn);

    always_comb begin
        w_x = '0;
        w_z = '0;
        w_cnt = '0;
        if (r_a_q[0]) begin w_x = w_x - w_dw; w_z = w_z - w_ds; w_cnt = w_cnt + 3'd1; end
        if (r_a_q[1]) begin w_x = w_x + w_de; w_z = w_z - w_ds; w_cnt = w_cnt + 3'd1; end
        if (r_a_q[2]) begin w_x = w_x + w_de; w_z = w_z + w_dn; w_cnt = w_cnt + 3'd1; end
        if (r_a_q[3]) begin w_x = w_x - w_dw; w_z = w_z + w_dn; w_cnt = w_cnt + 3'd1; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_deg <= (w_cnt == 3'd0);
            r_b_neg <= {w_z[SW-1], 1'b1, w_x[SW-1]};
            r_b_xm  <= w_x[SW-1] ? MW'(-w_x) : MW'(w_x);
            r_b_zm  <= w_z[SW-1] ? MW'(-w_z) : MW'(w_z);
            r_b_ym  <= {w_cnt, 8'd0};
        end
    end

    // stage c: squares
    logic                         r_c_vld, r_c_deg;
    logic [2:0]                   r_c_neg;
    logic [hvn_pkg::SQ_W-1:0]     r_c_x2, r_c_z2;
    logic [21:0]                  r_c_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            r_c_deg <= r_b_deg;
            r_c_neg <= r_b_neg;
            r_c_x2  <= r_b_xm * r_b_xm;
            r_c_z2  <= r_b_zm * r_b_zm;
            r_c_y2  <= r_b_ym * r_b_ym;
        end
    end

    // stage d: squared length, initial remainders
    localparam int DDW = hvn_pkg::D_W;
    logic [hvn_pkg::S_W-1:0] w_s;

    assign w_s = hvn_pkg::S_W'(r_c_x2) + hvn_pkg::S_W'(r_c_y2) + hvn_pkg::S_W'(r_c_z2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_it.vld <= 1'b0;
        end else if (i_en) begin
            o_it.vld <= r_c_vld;
        end
        if (i_en) begin
            o_it.deg <= r_c_deg;
            o_it.s   <= w_s;
            o_it.lane[0].neg <= r_c_neg[0];
            o_it.lane[1].neg <= r_c_neg[1];
            o_it.lane[2].neg <= r_c_neg[2];
            o_it.lane[0].d <= (DDW'(r_c_x2) << hvn_pkg::HALF_SHIFT) - DDW'(w_s);
            o_it.lane[1].d <= (DDW'(r_c_y2) << hvn_pkg::HALF_SHIFT) - DDW'(w_s);
            o_it.lane[2].d <= (DDW'(r_c_z2) << hvn_pkg::HALF_SHIFT) - DDW'(w_s);
            o_it.lane[0].p <= '0;
            o_it.lane[1].p <= '0;
            o_it.lane[2].p <= '0;
            o_it.lane[0].q <= '0;
            o_it.lane[1].q <= '0;
            o_it.lane[2].q <= '0;
        end
    end

endmodule

// ===== src/hvn_step.sv =====
module hvn_step #(
    parameter int BIT = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  hvn_pkg::t_iter  i_it,
    output hvn_pkg::t_iter  o_it
);

    localparam int DW = hvn_pkg::D_W;
    localparam int PW = hvn_pkg::P_W;

    // trial bit BIT: remainder drops by ((2P + (2^BIT - 1) s) << (BIT + 2))
    hvn_pkg::t_iter w_nx;
    logic [DW-1:0]  w_base;
    logic [DW-1:0]  w_diff [3];

    assign w_base = (DW'(i_it.s) << BIT) - DW'(i_it.s);

    always_comb begin
        w_nx = i_it;
        for (int l = 0; l < 3; l++) begin
            w_diff[l] = i_it.lane[l].d
                      - (((DW'(i_it.lane[l].p) << 1) + w_base) << (BIT + 2));
            if (!w_diff[l][DW-1] && !i_it.lane[l].d[DW-1]) begin
                w_nx.lane[l].d = w_diff[l];
                w_nx.lane[l].p = i_it.lane[l].p + (PW'(i_it.s) << BIT);
                w_nx.lane[l].q[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_it.vld <= 1'b0;
        end else if (i_en) begin
            o_it.vld <= w_nx.vld;
        end
        if (i_en) begin
            o_it.deg  <= w_nx.deg;
            o_it.s    <= w_nx.s;
            o_it.lane <= w_nx.lane;
        end
    end

endmodule

// ===== src/heightmap_vertex_normal_unit.sv =====
// Heightmap vertex normal unit.
// Slave stream takes one vertex word per cycle: tdata holds, from bit 0 up,
// column (12), row (12), then heights here, west, east, south, north (16 each,
// signed Q8.8). Master stream gives one word per vertex: tdata holds normal
// x, y, z (16 each, signed Q1.14) from bit 0 up; tuser is the degenerate flag.
// Grid size is set through the write port (index 0 columns, index 1 rows);
// the user must write it only while the unit is idle, which the unit does not
// enforce; values above MAX_GRID_DIM saturate. A vertex passes four front
// stages (edge differences, summed normal, squares, squared length), fifteen
// stages of the bit-serial square-root divide (one result bit per stage, all
// three components in parallel) and the output register before o_m_tvalid.
// Throughput is one vertex per cycle. The whole pipeline advances when the
// output register is empty or taken; while the receiver stalls, every stage
// holds and o_s_tready is low, so nothing is lost or repeated.
// Reset clears all valid bits and sets the grid to 256 by 256.
module heightmap_vertex_normal_unit #(
    parameter int MAX_GRID_DIM = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // col, row, height_here, height_west, height_east, height_south, height_north
    input  logic [hvn_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // normal_x, normal_y, normal_z
    output logic [hvn_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // degenerate
    output logic                              o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [hvn_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int CW = hvn_pkg::CFG_W;

    logic [CW-1:0] r_cols, r_rows, w_cfg_sat;

    assign w_cfg_sat = (int'(i_cfg_data) > MAX_GRID_DIM) ? CW'(MAX_GRID_DIM) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CW'(256);
            r_rows <= CW'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hvn_pkg::CFG_GRID_COLS: r_cols <= w_cfg_sat;
                hvn_pkg::CFG_GRID_ROWS: r_rows <= w_cfg_sat;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    hvn_pkg::t_iter w_it [hvn_pkg::STEPS+1];

    hvn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_col   (i_s_tdata[11:0]),
        .i_row   (i_s_tdata[23:12]),
        .i_h     (i_s_tdata[39:24]),
        .i_hw    (i_s_tdata[55:40]),
        .i_he    (i_s_tdata[71:56]),
        .i_hs    (i_s_tdata[87:72]),
        .i_hn    (i_s_tdata[103:88]),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .o_it    (w_it[0])
    );

    for (genvar g = 0; g < hvn_pkg::STEPS; g++) begin : g_step
        hvn_step #(
            .BIT (hvn_pkg::STEPS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_it    (w_it[g]),
            .o_it    (w_it[g+1])
        );
    end

    hvn_pkg::t_iter w_fin;
    logic [15:0]    w_n [3];

    assign w_fin = w_it[hvn_pkg::STEPS];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_fin.deg) begin
                w_n[l] = '0;
            end else if (w_fin.lane[l].neg) begin
                w_n[l] = -{1'b0, w_fin.lane[l].q};
            end else begin
                w_n[l] = {1'b0, w_fin.lane[l].q};
            end
        end
    end

    logic [hvn_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_fin.vld;
        end
        if (w_en) begin
            r_out_data <= {w_n[2], w_n[1], w_n[0]};
            r_out_deg  <= w_fin.deg;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("degenerate word with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16384 && $signed(o_m_tdata[15:0]) >= -16384
                     && $signed(o_m_tdata[31:16]) <= 16384 && $signed(o_m_tdata[31:16]) >= -16384
                     && $signed(o_m_tdata[47:32]) <= 16384 && $signed(o_m_tdata[47:32]) >= -16384))
        else $error("normal component out of unit range");

    a_cfg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cols) <= MAX_GRID_DIM && int'(r_rows) <= MAX_GRID_DIM)
        else $error("grid size above limit");

    a_y_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[31] == 1'b1)
        else $error("non-degenerate normal without negative y");

endmodule
